@@ sv/pgm_pkg.sv @@
package pgm_pkg;

    localparam int MAX_LOG2_SIZE_DEF = 8;
    localparam int CFG_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int LG_W = 5;
    localparam int S_W = 32;
    localparam int X_W = 32;
    localparam int FRAC_BITS = 30;
    localparam int NUM_W = X_W + FRAC_BITS;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG2_OUTER  = 2'd0,
        REG_LOG2_MIDDLE = 2'd1,
        REG_LOG2_INNER  = 2'd2
    } cfg_reg_t;

    // Work item handed from the front end to the divider pipeline.
    typedef struct packed {
        logic            dc;
        logic [S_W-1:0]  s;
        logic [LG_W-1:0] lg;
        logic [X_W-1:0]  re;
        logic [X_W-1:0]  im;
    } fe_item_t;

    // One stage of the divider pipeline.
    typedef struct packed {
        logic             dc;
        logic             neg_re;
        logic             neg_im;
        logic [X_W-1:0]   mag_re;
        logic [X_W-1:0]   mag_im;
        logic [S_W-1:0]   s;
        logic [LG_W-1:0]  lg;
        logic [S_W-1:0]   rem_re;
        logic [S_W-1:0]   rem_im;
        logic [NUM_W-1:0] q_re;
        logic [NUM_W-1:0] q_im;
    } div_st_t;

    // sin^2(pi*k/2^max_lg) in Q2.30; evaluated at elaboration only.
    function automatic logic [63:0] sin2_q30(input int unsigned k, input int unsigned max_lg);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic signed [63:0] sum;
        int unsigned sh;
        sh = max_lg + 10;
        x = ((PI_Q60 >> 20) * 64'(k) + (64'd1 << (sh - 1))) >> sh;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum = signed'(x);
        for (int i = 1; i <= 7; i++) begin
            term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if ((i % 2) == 1) sum = sum - signed'(term);
            else sum = sum + signed'(term);
        end
        if (sum < 0) sum = 0;
        s = unsigned'(sum);
        if (s > ONE_Q30) s = ONE_Q30;
        return (s * s + (64'd1 << 29)) >> 30;
    endfunction

endpackage

@@ sv/pgm_front.sv @@
module pgm_front #(
    parameter int MAX_LOG2_SIZE = pgm_pkg::MAX_LOG2_SIZE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [pgm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pgm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [87:0]                    s_tdata,
    input  logic                           q_full,
    output logic                           f_valid,
    output pgm_pkg::fe_item_t              f_item
);
    import pgm_pkg::*;

    localparam int KW = MAX_LOG2_SIZE;
    localparam int MW = MAX_LOG2_SIZE + 1;
    localparam int TBL_N = 2 ** (MAX_LOG2_SIZE - 1) + 1;

    logic [CFG_W-1:0] lg_reg [3];
    logic [CFG_W-1:0] lg_cl [3];
    logic [KW-1:0]    k_idx [3];
    logic [30:0]      sin2_tbl [TBL_N];
    logic [30:0]      term [3];
    logic             f_vld_reg, f_vld_next;
    fe_item_t         item_reg, item_next;
    logic             accept;

    for (genvar g = 0; g < TBL_N; g++) begin : g_tbl
        assign sin2_tbl[g] = 31'(sin2_q30(g, MAX_LOG2_SIZE));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lg_reg[0] <= CFG_W'(6);
            lg_reg[1] <= CFG_W'(6);
            lg_reg[2] <= CFG_W'(6);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LOG2_OUTER:  lg_reg[0] <= cfg_data;
                REG_LOG2_MIDDLE: lg_reg[1] <= cfg_data;
                REG_LOG2_INNER:  lg_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Fold each coordinate to its wrap-around frequency and look it up.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [MW-1:0] c, m, n;
        always_comb begin
            if (lg_reg[a] == '0) lg_cl[a] = CFG_W'(1);
            else if (lg_reg[a] > CFG_W'(MAX_LOG2_SIZE)) lg_cl[a] = CFG_W'(MAX_LOG2_SIZE);
            else lg_cl[a] = lg_reg[a];
            n = MW'(1) << lg_cl[a];
            c = MW'(s_tdata[8*a +: 8]) & (n - MW'(1));
            m = (c < (n >> 1)) ? c : (n - c);
            k_idx[a] = KW'(m << (CFG_W'(MAX_LOG2_SIZE) - lg_cl[a]));
            term[a] = sin2_tbl[k_idx[a]];
        end
    end

    assign s_tready = !f_vld_reg || !q_full;
    assign accept = s_tvalid && s_tready;

    always_comb begin
        item_next.s  = S_W'(term[0]) + S_W'(term[1]) + S_W'(term[2]);
        item_next.dc = (item_next.s == '0);
        item_next.lg = LG_W'(lg_cl[0]) + LG_W'(lg_cl[1]) + LG_W'(lg_cl[2]);
        item_next.re = s_tdata[55:24];
        item_next.im = s_tdata[87:56];
        if (accept) f_vld_next = 1'b1;
        else if (!q_full) f_vld_next = 1'b0;
        else f_vld_next = f_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) f_vld_reg <= 1'b0;
        else f_vld_reg <= f_vld_next;
    end

    always_ff @(posedge aclk) begin
        if (accept) item_reg <= item_next;
    end

    assign f_valid = f_vld_reg;
    assign f_item = item_reg;
endmodule

@@ sv/pgm_queue.sv @@
module pgm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  pgm_pkg::fe_item_t wr_item,
    input  logic              rd_en,
    output pgm_pkg::fe_item_t rd_item,
    output logic              full,
    output logic              empty
);
    import pgm_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    fe_item_t          mem [QUEUE_DEPTH];
    logic [PW-1:0]     wp_reg, rp_reg;
    logic [PW:0]       cnt_reg, cnt_next;

    assign full = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rd_item = mem[rp_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en) cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_item;
    end
endmodule

@@ sv/pgm_back.sv @@
module pgm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  pgm_pkg::fe_item_t q_item,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,
    output logic              m_tuser
);
    import pgm_pkg::*;

    localparam logic [NUM_W:0] POS_LIM = (NUM_W+1)'(33'h0_8000_0000);
    localparam logic [NUM_W:0] NEG_LIM = (NUM_W+1)'(33'h0_7FFF_FFFF);

    div_st_t     st_reg [NUM_W+1];
    div_st_t     st_next [NUM_W+1];
    logic        v_reg [NUM_W+1];
    logic        en;
    logic        out_vld_reg;
    logic [31:0] re_reg, im_reg, re_next, im_next;
    logic        sat_reg, sat_next;
    logic [NUM_W:0] qr_re, qr_im, half;

    assign en = !out_vld_reg || m_tready;
    assign q_pop = en && !q_empty;

    always_comb begin
        st_next[0] = '0;
        st_next[0].dc = q_item.dc;
        st_next[0].s = q_item.s;
        st_next[0].lg = q_item.lg;
        st_next[0].neg_re = q_item.re[X_W-1];
        st_next[0].neg_im = q_item.im[X_W-1];
        st_next[0].mag_re = q_item.re[X_W-1] ? (~q_item.re + 1'b1) : q_item.re;
        st_next[0].mag_im = q_item.im[X_W-1] ? (~q_item.im + 1'b1) : q_item.im;
    end

    // One quotient bit per stage of mag*2^30 / S, most significant bit first.
    for (genvar j = 0; j < NUM_W; j++) begin : g_div
        localparam int B = NUM_W - 1 - j;
        logic [S_W:0]   tr_re, tr_im;
        logic           nb_re, nb_im;
        logic [NUM_W-1:0] num_re, num_im;
        always_comb begin
            num_re = {st_reg[j].mag_re, FRAC_BITS'(0)};
            num_im = {st_reg[j].mag_im, FRAC_BITS'(0)};
            nb_re = num_re[B];
            nb_im = num_im[B];
            tr_re = {st_reg[j].rem_re, nb_re};
            tr_im = {st_reg[j].rem_im, nb_im};
            st_next[j+1] = st_reg[j];
            if (tr_re >= {1'b0, st_reg[j].s}) begin
                st_next[j+1].rem_re = S_W'(tr_re - {1'b0, st_reg[j].s});
                st_next[j+1].q_re[B] = 1'b1;
            end else begin
                st_next[j+1].rem_re = S_W'(tr_re);
            end
            if (tr_im >= {1'b0, st_reg[j].s}) begin
                st_next[j+1].rem_im = S_W'(tr_im - {1'b0, st_reg[j].s});
                st_next[j+1].q_im[B] = 1'b1;
            end else begin
                st_next[j+1].rem_im = S_W'(tr_im);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NUM_W; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= !q_empty;
            for (int i = 1; i <= NUM_W; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i <= NUM_W; i++) st_reg[i] <= st_next[i];
        end
    end

    // The divisor is S*2^lg, so the rounding step on the quotient by S is exact.
    always_comb begin
        half = (NUM_W+1)'(1) << (st_reg[NUM_W].lg - LG_W'(1));
        qr_re = ({1'b0, st_reg[NUM_W].q_re} + half) >> st_reg[NUM_W].lg;
        qr_im = ({1'b0, st_reg[NUM_W].q_im} + half) >> st_reg[NUM_W].lg;
        sat_next = 1'b0;
        if (st_reg[NUM_W].neg_re) begin
            if (qr_re > NEG_LIM) begin
                re_next = 32'h7FFF_FFFF;
                sat_next = 1'b1;
            end else begin
                re_next = qr_re[31:0];
            end
        end else begin
            if (qr_re > POS_LIM) begin
                re_next = 32'h8000_0000;
                sat_next = 1'b1;
            end else begin
                re_next = 32'd0 - qr_re[31:0];
            end
        end
        if (st_reg[NUM_W].neg_im) begin
            if (qr_im > NEG_LIM) begin
                im_next = 32'h7FFF_FFFF;
                sat_next = 1'b1;
            end else begin
                im_next = qr_im[31:0];
            end
        end else begin
            if (qr_im > POS_LIM) begin
                im_next = 32'h8000_0000;
                sat_next = 1'b1;
            end else begin
                im_next = 32'd0 - qr_im[31:0];
            end
        end
        if (st_reg[NUM_W].dc) begin
            re_next = '0;
            im_next = '0;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en) out_vld_reg <= v_reg[NUM_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_reg <= re_next;
            im_reg <= im_next;
            sat_reg <= sat_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata = {im_reg, re_reg};
    assign m_tuser = sat_reg;
endmodule

@@ sv/poisson_green_multiply_core.sv @@
// Channel  | Direction | Handshake          | Contents
// s_       | in        | s_tvalid/s_tready  | coordinates and complex Q16.16 sample
// m_       | out       | m_tvalid/m_tready  | scaled complex sample, saturation flag
// cfg_     | in        | cfg_valid/cfg_ready| log2 axis sizes
//
// One word is accepted per cycle and one result leaves per cycle while m_tready stays high.
// After the front register takes a word, it passes through the queue, the divider
// input register, 62 restoring divider stages (one quotient bit each) and the
// output register.
// Reset is synchronous and active low; the size registers return to 6.
// A stalled output freezes the divider pipeline; the four-entry queue and
// the front register keep taking words until they fill.
module poisson_green_multiply_core #(
    parameter int MAX_LOG2_SIZE = pgm_pkg::MAX_LOG2_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pgm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // coord_outer[7:0], coord_middle[15:8], coord_inner[23:16],
    // real_in[55:24], imag_in[87:56]
    input  logic [87:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // real_out[31:0], imag_out[63:32]
    output logic [63:0]                   m_tdata,
    // saturated[0]
    output logic                          m_tuser
);
    import pgm_pkg::*;

    logic     f_valid, q_full, q_empty, q_pop, q_push;
    fe_item_t f_item, q_item;

    assign cfg_ready = 1'b1;
    assign q_push = f_valid && !q_full;

    pgm_front #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .f_valid   (f_valid),
        .f_item    (f_item)
    );

    pgm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_push),
        .wr_item (f_item),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    pgm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule

@@ sv/pgm_checker.sv @@
module pgm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);
    // Nothing can come out in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid straight after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // A saturated word carries a clipped value in at least one part.
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[31:0] == 32'h7FFF_FFFF
            || m_tdata[31:0] == 32'h8000_0000 || m_tdata[63:32] == 32'h7FFF_FFFF
            || m_tdata[63:32] == 32'h8000_0000))
        else $error("saturation flag without a clipped part");

    // The input side keeps flowing while the output is idle.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(!m_tvalid) && $past(aresetn) && !s_tready |-> 1'b0 || m_tready
            || $past(s_tvalid))
        else $error("input stalled while the output is empty");
endmodule

bind poisson_green_multiply_core pgm_checker u_pgm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/poisson_green_multiply_core_test.sv @@
`timescale 1ns / 1ps

class green_scoreboard;
    logic [3:0] lg_outer;
    logic [3:0] lg_middle;
    logic [3:0] lg_inner;
    logic [63:0] sin2_lut [0:128];
    logic [64:0] expected_q [$];
    int errors;

    function new();
        logic [63:0] x, x2, term, s;
        logic signed [63:0] sum;
        lg_outer = 4'd6;
        lg_middle = 4'd6;
        lg_inner = 4'd6;
        errors = 0;
        // Quarter-wave table of sin^2 in Q2.30, built from a Taylor series.
        for (int k = 0; k <= 128; k++) begin
            x = ((64'h3243F6A8885A308D >> 20) * 64'(k) + (64'd1 << 17)) >> 18;
            x2 = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum = signed'(x);
            for (int i = 1; i <= 7; i++) begin
                term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
                if (i % 2 == 1) sum = sum - signed'(term);
                else sum = sum + signed'(term);
            end
            if (sum < 0) sum = 0;
            s = unsigned'(sum);
            if (s > 64'h40000000) s = 64'h40000000;
            sin2_lut[k] = (s * s + (64'd1 << 29)) >> 30;
        end
    endfunction

    function void write_size(pgm_pkg::cfg_reg_t idx, logic [3:0] val);
        case (idx)
            pgm_pkg::REG_LOG2_OUTER:  lg_outer = val;
            pgm_pkg::REG_LOG2_MIDDLE: lg_middle = val;
            pgm_pkg::REG_LOG2_INNER:  lg_inner = val;
            default: ;
        endcase
    endfunction

    function int unsigned eff_lg(logic [3:0] v);
        if (v == 0) return 1;
        if (v > 8) return 8;
        return v;
    endfunction

    function logic [63:0] axis_sin2(logic [7:0] coord, int unsigned lg);
        int unsigned n, c, m;
        n = 1 << lg;
        c = coord & (n - 1);
        m = (c < n / 2) ? c : n - c;
        return sin2_lut[m << (8 - lg)];
    endfunction

    function logic [31:0] scale(logic [31:0] x, logic [63:0] s, int unsigned lg,
                                inout logic sat);
        logic [127:0] mag, num, den, q;
        mag = x[31] ? 128'(33'h100000000 - 33'(x)) : 128'(x);
        num = mag << 30;
        den = 128'(s) << lg;
        q = (num + (den >> 1)) / den;
        if (x[31]) begin
            if (q > 128'h7FFFFFFF) begin
                q = 128'h7FFFFFFF;
                sat = 1'b1;
            end
            return q[31:0];
        end
        if (q > 128'h80000000) begin
            q = 128'h80000000;
            sat = 1'b1;
        end
        return 32'(33'h100000000 - q[32:0]);
    endfunction

    function void note_sample(logic [87:0] word);
        int unsigned lo, lm, li;
        logic [63:0] s;
        logic sat;
        logic [31:0] re, im;
        lo = eff_lg(lg_outer);
        lm = eff_lg(lg_middle);
        li = eff_lg(lg_inner);
        s = axis_sin2(word[7:0], lo) + axis_sin2(word[15:8], lm)
            + axis_sin2(word[23:16], li);
        sat = 1'b0;
        if (s == 0) begin
            re = 0;
            im = 0;
        end else begin
            re = scale(word[55:24], s, lo + lm + li, sat);
            im = scale(word[87:56], s, lo + lm + li, sat);
        end
        expected_q.push_back({sat, im, re});
    endfunction

    function void check_result(logic [63:0] data, logic flag);
        logic [64:0] exp_w;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h sat %b", $time, data, flag);
            errors++;
            return;
        end
        exp_w = expected_q.pop_front();
        if (data[31:0] !== exp_w[31:0]) begin
            $display("%0t: real_out expected %h actual %h", $time, exp_w[31:0], data[31:0]);
            errors++;
        end
        if (data[63:32] !== exp_w[63:32]) begin
            $display("%0t: imag_out expected %h actual %h", $time, exp_w[63:32],
                     data[63:32]);
            errors++;
        end
        if (flag !== exp_w[64]) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_w[64], flag);
            errors++;
        end
    endfunction
endclass

module poisson_green_multiply_core_test;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    green_scoreboard sb = new();
    bit   calm = 1'b0;
    int   hold_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    poisson_green_multiply_core u_dut (.*);

    // Result side: random back-pressure, a quiet stretch, and one long hold-off.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
        end
    end

    task automatic write_reg(pgm_pkg::cfg_reg_t idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_size(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(logic [3:0] o, logic [3:0] m, logic [3:0] i);
        write_reg(pgm_pkg::REG_LOG2_OUTER, o);
        write_reg(pgm_pkg::REG_LOG2_MIDDLE, m);
        write_reg(pgm_pkg::REG_LOG2_INNER, i);
    endtask

    task automatic send_word(logic [87:0] word);
        while (!calm && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(word);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF;
            1: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_coord();
        case ($urandom_range(3))
            0: return 8'($urandom_range(3));
            1: return 8'hFF - 8'($urandom_range(3));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_words(int count);
        for (int k = 0; k < count; k++)
            send_word({rand_sample(), rand_sample(), rand_coord(), rand_coord(),
                       rand_coord()});
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words at reset sizes: DC cell, extremes, Nyquist, high bits.
        send_word({32'h12345678, 32'h7FFFFFFF, 8'd0, 8'd0, 8'd0});
        send_word({32'h80000000, 32'h7FFFFFFF, 8'd0, 8'd0, 8'd1});
        send_word({32'h80000000, 32'h80000000, 8'd32, 8'd32, 8'd32});
        send_word({32'h00000001, 32'hFFFFFFFF, 8'd1, 8'd0, 8'd0});
        send_word({32'h7FFFFFFF, 32'h00000000, 8'd63, 8'd33, 8'd31});
        send_word({32'h00010000, 32'hFFFF0000, 8'hC0, 8'h40, 8'hFF});
        drain();
        set_sizes(4'd1, 4'd8, 4'd0);
        send_word({32'hFFFFFFFF, 32'h80000000, 8'd1, 8'd128, 8'd3});
        send_word({32'h7FFFFFFF, 32'h80000000, 8'd2, 8'd0, 8'd0});
        send_word({32'h00000000, 32'h00000001, 8'd0, 8'd255, 8'd1});
        drain();
        set_sizes(4'd15, 4'd9, 4'd8);
        send_word({32'h7FFFFFFF, 32'h80000000, 8'd0, 8'd0, 8'd128});
        send_word({32'h00000001, 32'h00000001, 8'd255, 8'd255, 8'd255});
        drain();

        // Long result hold-off while words keep coming, to fill the block.
        hold_cycles = 150;
        random_words(100);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            set_sizes(4'($urandom_range(15)), 4'($urandom_range(15)),
                      4'($urandom_range(15)));
            calm = (phase == 3);
            random_words(120);
            drain();
        end
        set_sizes(4'd1, 4'd1, 4'd1);
        random_words(30);
        drain();

        if (sb.errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule

@@ poisson_green_multiply_core.f @@
sv/pgm_pkg.sv
sv/pgm_front.sv
sv/pgm_queue.sv
sv/pgm_back.sv
sv/poisson_green_multiply_core.sv
sv/pgm_checker.sv
tb/sv/poisson_green_multiply_core_test.sv
